@@ rtl/core/qpsk_evm_running_mean_assert.svh @@
// Assertion macros used by the checker file of the EVM block.
`ifndef QPSK_EVM_RUNNING_MEAN_ASSERT_SVH
`define QPSK_EVM_RUNNING_MEAN_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define QEVM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// A signal that must not change while a transfer is stalled.
`define QEVM_ASSERT_HOLD(label, cond, sig, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		cond |=> $stable(sig)) else $error(msg);

`endif

@@ rtl/core/qevm_pkg.sv @@
// Types, constants and helper functions of the QPSK EVM running mean block.
package qevm_pkg;
	localparam int SAMPLE_W = 16;
	localparam int AMP_W    = 15;
	localparam int LIMIT_W  = 24;
	localparam int COUNT_W  = LIMIT_W + 1;
	localparam int EVM_W    = 20;
	localparam int ERR_W    = 15;

	localparam logic [EVM_W-1:0]   EVM_MAX     = '1;
	localparam logic [AMP_W-1:0]   AMP_RESET   = 15'd16384;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 24'd1000000;

	// Configuration register indexes.
	localparam logic REG_AMP   = 1'b0;
	localparam logic REG_LIMIT = 1'b1;

	typedef struct packed {
		logic               start;
		logic [ERR_W-1:0]   ex;
		logic [ERR_W-1:0]   ey;
		logic [AMP_W-1:0]   amp;
		logic [LIMIT_W-1:0] n;
		logic [EVM_W-1:0]   mean;
	} qevm_job_t;

	typedef struct packed {
		logic             done;
		logic [EVM_W-1:0] mean;
	} qevm_res_t;

	// Distance of one component from the nearest ideal level, sign picked by the sample.
	function automatic logic [ERR_W-1:0] abs_err(input logic signed [SAMPLE_W-1:0] v,
			input logic [AMP_W-1:0] a);
		logic signed [SAMPLE_W:0] vs;
		logic signed [SAMPLE_W:0] as;
		logic signed [SAMPLE_W:0] d;
		logic signed [SAMPLE_W:0] nd;
		vs = {v[SAMPLE_W-1], v};
		as = {2'b00, a};
		d = (v > 0) ? (vs - as) : (vs + as);
		nd = -d;
		return d[SAMPLE_W] ? nd[ERR_W-1:0] : d[ERR_W-1:0];
	endfunction
endpackage

@@ rtl/core/qevm_core.sv @@
// Bit-serial arithmetic unit: squares, square root, normalization and mean update.
module qevm_core import qevm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  qevm_job_t job,
	output qevm_res_t res
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SQ1  = 3'd1;
	localparam logic [2:0] ST_SQ2  = 3'd2;
	localparam logic [2:0] ST_SQRT = 3'd3;
	localparam logic [2:0] ST_DIV1 = 3'd4;
	localparam logic [2:0] ST_MUL  = 3'd5;
	localparam logic [2:0] ST_ADD  = 3'd6;
	localparam logic [2:0] ST_DIV2 = 3'd7;

	logic [2:0]         st_q;
	logic [5:0]         cnt_q;
	logic [ERR_W-1:0]   ex_q, ey_q;
	logic [AMP_W-1:0]   amp_q;
	logic [LIMIT_W-1:0] n_q;
	logic [EVM_W-1:0]   mean_q, e_q, res_q;
	logic [30:0]        m_q, rem_q;
	logic [59:0]        x_q;
	logic [29:0]        root_q;
	logic [31:0]        q_q;
	logic [44:0]        acc_q;
	logic               done_q;

	logic [30:0]        sq_ex, sq_ey, m_sum;
	logic [32:0]        rs, tr;
	logic               ge;
	logic [15:0]        d1;
	logic               ge1;
	logic [24:0]        d2;
	logic               ge2;
	logic [LIMIT_W-1:0] nm1;
	logic [44:0]        acc_n;
	logic [31:0]        qf1, qf2;

	always_comb begin
		sq_ex = {16'b0, ex_q} * {16'b0, ex_q};
		sq_ey = {16'b0, ey_q} * {16'b0, ey_q};
		m_sum = m_q + sq_ey;
		rs = {rem_q, x_q[59:58]};
		tr = {1'b0, root_q, 2'b01};
		ge = rs >= tr;
		d1 = {rem_q[14:0], x_q[59]};
		ge1 = d1 >= {1'b0, amp_q};
		d2 = {rem_q[23:0], x_q[59]};
		ge2 = d2 >= {1'b0, n_q};
		nm1 = n_q - 1'b1;
		acc_n = {acc_q[43:0], 1'b0} + (x_q[59] ? {21'b0, nm1} : 45'b0);
		qf1 = {q_q[30:0], ge1};
		qf2 = {q_q[30:0], ge2};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				ST_IDLE: if (job.start) st_q <= ST_SQ1;
				ST_SQ1:  st_q <= ST_SQ2;
				ST_SQ2:  st_q <= ST_SQRT;
				ST_SQRT: if (cnt_q == 6'd0) st_q <= ST_DIV1;
				ST_DIV1: if (cnt_q == 6'd0) st_q <= ST_MUL;
				ST_MUL:  if (cnt_q == 6'd0) st_q <= ST_ADD;
				ST_ADD:  st_q <= ST_DIV2;
				ST_DIV2: begin
					if (cnt_q == 6'd0) begin
						st_q <= ST_IDLE;
						done_q <= 1'b1;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		cnt_q <= cnt_q - 6'd1;
		case (st_q)
			ST_IDLE: begin
				ex_q <= job.ex;
				ey_q <= job.ey;
				amp_q <= job.amp;
				n_q <= job.n;
				mean_q <= job.mean;
			end
			ST_SQ1: m_q <= sq_ex;
			ST_SQ2: begin
				x_q <= {1'b0, m_sum, 28'b0};
				rem_q <= '0;
				root_q <= '0;
				cnt_q <= 6'd29;
			end
			ST_SQRT: begin
				root_q <= {root_q[28:0], ge};
				if (cnt_q == 6'd0) begin
					// Root is complete; start dividing 4*root by the amplitude.
					x_q <= {root_q[28:0], ge, 2'b00, 28'b0};
					rem_q <= '0;
					cnt_q <= 6'd31;
				end else begin
					rem_q <= ge ? 31'(rs - tr) : rs[30:0];
					x_q <= {x_q[57:0], 2'b00};
				end
			end
			ST_DIV1: begin
				rem_q <= {15'b0, ge1 ? (d1 - {1'b0, amp_q}) : d1};
				q_q <= qf1;
				x_q <= {x_q[58:0], 1'b0};
				if (cnt_q == 6'd0) begin
					e_q <= (qf1[31:20] != 12'd0) ? EVM_MAX : qf1[19:0];
					x_q <= {mean_q, 40'b0};
					acc_q <= '0;
					cnt_q <= 6'd19;
				end
			end
			ST_MUL: begin
				acc_q <= acc_n;
				x_q <= {x_q[58:0], 1'b0};
			end
			ST_ADD: begin
				x_q <= {acc_q + {25'b0, e_q}, 15'b0};
				rem_q <= '0;
				cnt_q <= 6'd44;
			end
			ST_DIV2: begin
				rem_q <= {6'b0, ge2 ? (d2 - {1'b0, n_q}) : d2};
				q_q <= qf2;
				x_q <= {x_q[58:0], 1'b0};
				if (cnt_q == 6'd0) res_q <= qf2[19:0];
			end
			default: ;
		endcase
	end

	assign res.done = done_q;
	assign res.mean = res_q;
endmodule

@@ rtl/core/qpsk_evm_running_mean.sv @@
// QPSK EVM running mean: top level with handshake, counter and configuration.
// Each sample is passed through with the mean EVM after it. One sample is in
// work at a time. A sample that is averaged goes through the bit-serial unit
// from transfer in to result: the squares, 30 square root steps, 32 steps
// dividing by the amplitude, 20 steps of the count-times-mean product, one
// add and 45 steps dividing by the count; then the new mean is taken and the
// output register loaded. A sample that is not averaged (a zero component or
// the limit passed) goes to the output register without the unit. A finished
// result waits in the output register while the next sample is taken in.
module qpsk_evm_running_mean import qevm_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [LIMIT_W-1:0]         cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [SAMPLE_W-1:0] sample_i,
	input  logic signed [SAMPLE_W-1:0] sample_q,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [SAMPLE_W-1:0] pass_i,
	output logic signed [SAMPLE_W-1:0] pass_q,
	output logic [EVM_W-1:0]           evm_estimate,
	output logic                       limit_reached
);
	logic [AMP_W-1:0]          amp_q;
	logic [LIMIT_W-1:0]        limit_q;
	logic [COUNT_W-1:0]        count_q, count_n;
	logic [EVM_W-1:0]          mean_q;
	logic                      busy_q, fin_q, out_valid_q;
	logic signed [SAMPLE_W-1:0] hold_i_q, hold_q_q;
	logic                      lim_q;
	logic                      in_xfer, may_avg, avg, load_out;
	qevm_job_t                 job;
	qevm_res_t                 res;

	assign in_xfer = in_valid && in_ready;
	assign in_ready = !busy_q;
	assign load_out = fin_q && (!out_valid_q || out_ready);

	always_comb begin
		if (count_q <= {1'b0, limit_q}) begin
			count_n = count_q + 1'b1;
			may_avg = count_n <= {1'b0, limit_q};
		end else begin
			count_n = count_q;
			may_avg = 1'b0;
		end
		avg = may_avg && (sample_i != '0) && (sample_q != '0);
		job.start = in_xfer && avg;
		job.ex = abs_err(sample_i, amp_q);
		job.ey = abs_err(sample_q, amp_q);
		job.amp = amp_q;
		job.n = count_n[LIMIT_W-1:0];
		job.mean = mean_q;
	end

	qevm_core u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.job   (job),
		.res   (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amp_q <= AMP_RESET;
			limit_q <= LIMIT_RESET;
			count_q <= '0;
			mean_q <= '0;
			busy_q <= 1'b0;
			fin_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_AMP:   amp_q <= cfg_data[AMP_W-1:0];
					REG_LIMIT: limit_q <= cfg_data;
					default: ;
				endcase
			end
			if (in_xfer) begin
				count_q <= count_n;
				busy_q <= 1'b1;
				fin_q <= !avg;
			end
			if (res.done) begin
				mean_q <= res.mean;
				fin_q <= 1'b1;
			end
			if (load_out) begin
				fin_q <= 1'b0;
				busy_q <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			hold_i_q <= sample_i;
			hold_q_q <= sample_q;
			lim_q <= count_n > {1'b0, limit_q};
		end
		if (load_out) begin
			pass_i <= hold_i_q;
			pass_q <= hold_q_q;
			limit_reached <= lim_q;
			evm_estimate <= res.done ? res.mean : mean_q;
		end
	end

	assign out_valid = out_valid_q;
endmodule

@@ rtl/core/qevm_check.sv @@
// Port checker for the QPSK EVM block and its bind to the top level.
`include "qpsk_evm_running_mean_assert.svh"

module qevm_check import qevm_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic [EVM_W-1:0] evm_estimate
);
	// Only one sample is in work, so ready drops after every input transfer.
	`QEVM_ASSERT(a_one_in_work, in_valid && in_ready |=> !in_ready, "second sample taken")
	// A new result appears only while a sample was held in work.
	`QEVM_ASSERT(a_result_from_work, $rose(out_valid) |-> $past(!in_ready), "result from nowhere")
	`QEVM_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped")
	`QEVM_ASSERT_HOLD(a_evm_hold, out_valid && !out_ready, evm_estimate, "stalled EVM changed")
endmodule

bind qpsk_evm_running_mean qevm_check u_chk (.*);
